### rtl/core/layered_modular_fenwick_tree_top_defines.svh
// ----------------------------------------------------------------------------
// Layered modular Fenwick tree: assertion macros
// Shared assertion shorthands, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LAYERED_MODULAR_FENWICK_TREE_TOP_DEFINES_SVH
`define LAYERED_MODULAR_FENWICK_TREE_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define LMFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define LMFT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/core/lmft_pkg.sv
// ----------------------------------------------------------------------------
// lmft_pkg
// Shared constants, types and functions of the layered modular Fenwick tree.
// ----------------------------------------------------------------------------
package lmft_pkg;

  localparam int DATA_W  = 30;
  localparam int NODE_W  = 32;
  localparam int VALUE_W = 31;
  localparam int INDEX_W = 11;
  localparam int LAYER_W = 5;
  localparam int CFG_W   = 11;

  localparam int SIZE_DEFAULT   = 1024;
  localparam int LAYERS_DEFAULT = 32;

  localparam logic [DATA_W-1:0] PRIME       = 30'd1000000007;
  localparam logic [CFG_W-1:0]  SIZE_RESET  = 11'd1024;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  // Reduces a signed 31-bit amount to its residue in 0..PRIME-1. A negative
  // amount whose magnitude exceeds the prime leaves a word wrapped in 32 bits,
  // which the node arithmetic then carries modulo 2**32.
  function automatic logic [NODE_W-1:0] residue(input logic signed [VALUE_W-1:0] v);
    logic [NODE_W-1:0] bits;
    logic [NODE_W-1:0] mag;
    logic [NODE_W-1:0] red;
    bits = {1'b0, v};
    mag  = (NODE_W'(1) << VALUE_W) - bits;
    if (bits[VALUE_W-1]) begin
      red = NODE_W'(PRIME) - mag;
    end else if (bits >= NODE_W'(PRIME)) begin
      red = bits - NODE_W'(PRIME);
    end else begin
      red = bits;
    end
    return red;
  endfunction

endpackage

### rtl/core/lmft_modadd.sv
// ----------------------------------------------------------------------------
// lmft_modadd
// Modular adder shared by every node update and every prefix accumulation.
// ----------------------------------------------------------------------------
module lmft_modadd (
  input  logic [lmft_pkg::NODE_W-1:0] a_i,
  input  logic [lmft_pkg::NODE_W-1:0] b_i,
  output logic [lmft_pkg::NODE_W-1:0] sum_o
);

  logic [lmft_pkg::NODE_W-1:0] raw;

  // The sum wraps in 32 bits and is then reduced by one conditional subtract.
  assign raw   = a_i + b_i;
  assign sum_o = (raw >= lmft_pkg::NODE_W'(lmft_pkg::PRIME)) ?
                 raw - lmft_pkg::NODE_W'(lmft_pkg::PRIME) : raw;

endmodule

### rtl/core/lmft_ram.sv
// ----------------------------------------------------------------------------
// lmft_ram
// Node store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lmft_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lmft_pkg::NODE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lmft_pkg::NODE_W-1:0] rdata_o
);

  logic [lmft_pkg::NODE_W-1:0] mem [DEPTH];
  logic [lmft_pkg::NODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lmft_ctrl.sv
// ----------------------------------------------------------------------------
// lmft_ctrl
// Sequencer: clears the store after reset, then walks the tree nodes of one
// item, one memory read per cycle, through the shared modular adder.
// ----------------------------------------------------------------------------
`include "layered_modular_fenwick_tree_top_defines.svh"

module lmft_ctrl #(
  parameter int SIZE   = lmft_pkg::SIZE_DEFAULT,
  parameter int LAYERS = lmft_pkg::LAYERS_DEFAULT,
  parameter int NW     = $clog2(SIZE),
  parameter int LW     = (LAYERS > 1) ? $clog2(LAYERS) : 1,
  parameter int AW     = LW + NW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [lmft_pkg::LAYER_W-1:0]        layer_i,
  input  logic [lmft_pkg::INDEX_W-1:0]        index_i,
  input  logic signed [lmft_pkg::VALUE_W-1:0] value_i,
  input  logic [lmft_pkg::CFG_W-1:0]          size_in_use_i,
  output logic                                result_valid_o,
  output logic [lmft_pkg::DATA_W-1:0]         prefix_sum_o,
  output logic                                mem_we_o,
  output logic [AW-1:0]                       mem_waddr_o,
  output logic [lmft_pkg::NODE_W-1:0]         mem_wdata_o,
  output logic                                mem_re_o,
  output logic [AW-1:0]                       mem_raddr_o,
  input  logic [lmft_pkg::NODE_W-1:0]         mem_rdata_i
);

  localparam int DEPTH = LAYERS << NW;
  localparam int SW    = $clog2(SIZE + 1);
  localparam int PW    = ((lmft_pkg::INDEX_W > SW) ? lmft_pkg::INDEX_W : SW) + 1;

  lmft_pkg::state_e            state_q, state_d;
  logic [PW-1:0]               pos_q, pos_d;
  logic [PW-1:0]               limit_q, limit_d;
  logic                        op_q, op_d;
  logic [LW-1:0]               layer_q, layer_d;
  logic [lmft_pkg::NODE_W-1:0] r_q, r_d;
  logic [lmft_pkg::NODE_W-1:0] acc_q, acc_d;
  logic                        rd_v_q, rd_v_d;
  logic [AW-1:0]               waddr_q, waddr_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic                        res_v_q, res_v_d;

  logic [PW-1:0]               lowbit;
  logic [PW-1:0]               pos_next;
  logic [PW-1:0]               node;
  logic [AW-1:0]               addr;
  logic                        go;
  logic                        layer_ok;
  logic [PW-1:0]               idx_ext;
  logic [PW-1:0]               cap;
  logic [lmft_pkg::NODE_W-1:0] alu_b;
  logic [lmft_pkg::NODE_W-1:0] alu_sum;

  // Lowest set bit steps the walk up for an add and down for a query.
  assign lowbit   = pos_q & ((~pos_q) + PW'(1));
  assign pos_next = (op_q == lmft_pkg::OP_ADD) ? pos_q + lowbit : pos_q - lowbit;
  assign go       = (pos_q != '0) && (pos_q <= limit_q);
  assign node     = pos_q - PW'(1);
  assign addr     = {layer_q, node[NW-1:0]};

  assign layer_ok = 32'(layer_i) < 32'(LAYERS);
  assign idx_ext  = PW'(index_i);
  assign cap      = (PW'(size_in_use_i) > PW'(SIZE)) ? PW'(SIZE) : PW'(size_in_use_i);

  assign alu_b = (op_q == lmft_pkg::OP_ADD) ? r_q : acc_q;

  lmft_modadd u_modadd (
    .a_i   (mem_rdata_i),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmft_pkg::ST_CLEAR;
      clr_q   <= '0;
      rd_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rd_v_q  <= rd_v_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    limit_q <= limit_d;
    op_q    <= op_d;
    layer_q <= layer_d;
    r_q     <= r_d;
    acc_q   <= acc_d;
    waddr_q <= waddr_d;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    limit_d     = limit_q;
    op_d        = op_q;
    layer_d     = layer_q;
    r_d         = r_q;
    acc_d       = acc_q;
    rd_v_d      = 1'b0;
    waddr_d     = waddr_q;
    clr_d       = clr_q;
    res_v_d     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = waddr_q;
    mem_wdata_o = alu_sum;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr;

    unique case (state_q)
      lmft_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = lmft_pkg::ST_IDLE;
        end
      end
      lmft_pkg::ST_IDLE: begin
        if (start) begin
          state_d = lmft_pkg::ST_WALK;
          op_d    = op_i;
          layer_d = LW'(layer_i);
          r_d     = lmft_pkg::residue(value_i);
          acc_d   = '0;
          if (op_i == lmft_pkg::OP_ADD) begin
            pos_d   = layer_ok ? idx_ext : '0;
            limit_d = cap;
          end else begin
            pos_d   = !layer_ok ? '0 : ((idx_ext > PW'(SIZE)) ? PW'(SIZE) : idx_ext);
            limit_d = PW'(SIZE);
          end
        end
      end
      lmft_pkg::ST_WALK: begin
        // Issue the next node read while the previous node's data is folded in.
        if (go) begin
          mem_re_o = 1'b1;
          rd_v_d   = 1'b1;
          waddr_d  = addr;
          pos_d    = pos_next;
        end
        if (rd_v_q) begin
          if (op_q == lmft_pkg::OP_ADD) begin
            mem_we_o = 1'b1;
          end else begin
            acc_d = alu_sum;
          end
        end
        if (!go && !rd_v_q) begin
          state_d = lmft_pkg::ST_IDLE;
          res_v_d = (op_q == lmft_pkg::OP_QUERY);
        end
      end
      default: begin
        state_d = lmft_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != lmft_pkg::ST_IDLE);
  assign result_valid_o = res_v_q;
  assign prefix_sum_o   = acc_q[lmft_pkg::DATA_W-1:0];

  `LMFT_ASSERT_NEVER(a_rw_same_node, mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o), "node read and written in the same cycle")
  `LMFT_ASSERT(a_result_after_walk, res_v_q |-> ($past(state_q) == lmft_pkg::ST_WALK && !busy), "result strobe outside the end of a walk")
  `LMFT_ASSERT_NEVER(a_read_pipe_idle, rd_v_q && (state_q != lmft_pkg::ST_WALK), "read data pending outside a walk")

endmodule

### rtl/core/layered_modular_fenwick_tree_top.sv
// ----------------------------------------------------------------------------
// layered_modular_fenwick_tree_top
// LAYERS independent Fenwick trees of SIZE nodes holding residues mod
// 1000000007, with add and prefix-sum query commands.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it writes zero to every node. An
// item is transferred when start is high and busy is low. The item then
// visits n tree nodes (at most log2(SIZE)+1, so 11 with the defaults), one
// read of the single node memory port per cycle; busy stays high until the
// walk is done. A query result is shown on prefix_sum_o for exactly one
// cycle, marked by result_valid_o, in the first cycle that busy is low
// again; the receiver cannot stall it. An add gives no result. Write
// size_in_use only while busy is low.
module layered_modular_fenwick_tree_top #(
  parameter int SIZE   = lmft_pkg::SIZE_DEFAULT,
  parameter int LAYERS = lmft_pkg::LAYERS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [lmft_pkg::LAYER_W-1:0]        layer_i,
  input  logic [lmft_pkg::INDEX_W-1:0]        index_i,
  input  logic signed [lmft_pkg::VALUE_W-1:0] value_i,
  input  logic                                size_in_use_we_i,
  input  logic [lmft_pkg::CFG_W-1:0]          size_in_use_i,
  output logic                                result_valid_o,
  output logic [lmft_pkg::DATA_W-1:0]         prefix_sum_o
);

  localparam int NW    = $clog2(SIZE);
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int AW    = LW + NW;
  localparam int DEPTH = LAYERS << NW;

  logic [lmft_pkg::CFG_W-1:0]  size_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lmft_pkg::NODE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [lmft_pkg::NODE_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= lmft_pkg::SIZE_RESET;
    end else if (size_in_use_we_i) begin
      size_q <= size_in_use_i;
    end
  end

  lmft_ctrl #(
    .SIZE   (SIZE),
    .LAYERS (LAYERS),
    .NW     (NW),
    .LW     (LW),
    .AW     (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .layer_i        (layer_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .size_in_use_i  (size_q),
    .result_valid_o (result_valid_o),
    .prefix_sum_o   (prefix_sum_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  lmft_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
